[rtl/sfd_pkg.sv]
// shared types and constants for the stereo feedback delay
// no dependencies; used by sfd_rem, sfd_lane and stereo_feedback_delay
`timescale 1ns / 1ps

package sfd_pkg;

	localparam int SFD_STORE_DEPTH = 131072;
	localparam int SFD_SAMPLE_BITS = 24;
	localparam int DELAY_BITS      = 17;
	localparam int GAIN_BITS       = 16;
	localparam int ROUND_HALF      = 16384;
	localparam int OUT_DEPTH       = 8;
	localparam int APB_ADDR_BITS   = 4;
	localparam int APB_DATA_BITS   = 32;

	localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'h8000;

	typedef enum logic [1:0] {
		REG_DELAY,
		REG_FEEDBACK,
		REG_MIX
	} sfd_reg_t;

	typedef struct packed {
		logic                 bypass;
		logic                 hit;
		logic [GAIN_BITS-1:0] fb;
		logic [GAIN_BITS-1:0] mix;
	} sfd_ctl_t;

endpackage

[rtl/sfd_rem.sv]
// remainder of the delay length by the store depth, by reciprocal multiplication
// depends on sfd_pkg
`timescale 1ns / 1ps

module sfd_rem #(
	parameter int DEPTH = sfd_pkg::SFD_STORE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [sfd_pkg::DELAY_BITS-1:0]    dividend,
	output logic [$clog2(DEPTH)-1:0]          rem,
	output logic                              busy
);

	localparam int AW = $clog2(DEPTH);
	localparam int NB = sfd_pkg::DELAY_BITS;
	localparam int MW = NB + 1;
	localparam int KS = NB + AW;
	localparam longint unsigned RECIP = ((64'd1 << KS) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
	localparam logic [MW-1:0] RECIP_W = MW'(RECIP);
	localparam logic [NB-1:0] DEPTH_N = NB'(DEPTH);

	logic [1:0]       stage_q;
	logic [NB-1:0]    dvd_q;
	logic [NB+MW-1:0] prod_s1;
	logic [AW-1:0]    rem_q;
	logic [NB-1:0]    quo;
	logic [NB-1:0]    back;
	logic [NB-1:0]    diff;

	// quotient from the scaled product, then one constant multiply and subtract
	assign quo  = NB'(prod_s1 >> KS);
	assign back = quo * DEPTH_N;
	assign diff = dvd_q - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
			dvd_q   <= '0;
			prod_s1 <= '0;
			rem_q   <= '0;
		end else begin
			stage_q <= {stage_q[0], start};
			if (start) begin
				dvd_q <= dividend;
			end
			if (stage_q[0]) begin
				prod_s1 <= dvd_q * RECIP_W;
			end
			if (stage_q[1]) begin
				rem_q <= AW'(diff);
			end
		end
	end

	assign rem  = rem_q;
	assign busy = |stage_q;

endmodule

[rtl/sfd_lane.sv]
// one channel of the echo: circular store, gain products, rounding and saturation
// depends on sfd_pkg
`timescale 1ns / 1ps

module sfd_lane #(
	parameter int DEPTH = sfd_pkg::SFD_STORE_DEPTH,
	parameter int W     = sfd_pkg::SFD_SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     acc,
	input  logic [W-1:0]             smp,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  sfd_pkg::sfd_ctl_t        ctl,
	output logic                     out_valid,
	output logic [W-1:0]             out_smp
);

	localparam int AW = $clog2(DEPTH);
	localparam int GW = sfd_pkg::GAIN_BITS + 1;
	localparam int PW = W + GW;

	logic [W-1:0] mem [DEPTH];

	logic              v_s1;
	sfd_pkg::sfd_ctl_t ctl_s1;
	logic [W-1:0]      in_s1;
	logic [AW-1:0]     wa_s1;
	logic [W-1:0]      rdata_s1;

	logic              v_s2;
	logic              bypass_s2;
	logic [W-1:0]      in_s2;
	logic [AW-1:0]     wa_s2;
	logic [PW-1:0]     pfb_s2;
	logic [PW-1:0]     pwet_s2;
	logic [PW-1:0]     pdry_s2;

	logic              v_s3;
	logic [W-1:0]      out_s3;

	logic [W-1:0]      delayed;
	logic [GW-1:0]     dry_gain;
	logic signed [PW-1:0] pfb_c;
	logic signed [PW-1:0] pwet_c;
	logic signed [PW-1:0] pdry_c;

	logic [W+17:0]     fb_round;
	logic [W+3:0]      back_sum;
	logic [W+18:0]     out_round;
	logic [W-1:0]      back_sat;
	logic [W-1:0]      out_sat;
	logic              wen_s2;

	function automatic logic [W-1:0] sat(input logic [W+3:0] v);
		logic [4:0] upper;
		logic [W-1:0] res;
		upper = v[W+3:W-1];
		if ((&upper) || !(|upper)) begin
			res = v[W-1:0];
		end else if (v[W+3]) begin
			res = {1'b1, {(W-1){1'b0}}};
		end else begin
			res = {1'b0, {(W-1){1'b1}}};
		end
		return res;
	endfunction

	// store read, registered
	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// store write-back
	always_ff @(posedge clk) begin
		if (wen_s2) begin
			mem[wa_s2] <= back_sat;
		end
	end

	// stage 1: products
	assign delayed  = ctl_s1.hit ? rdata_s1 : '0;
	assign dry_gain = GW'(sfd_pkg::GAIN_ONE) - {1'b0, ctl_s1.mix};
	assign pfb_c    = $signed(delayed) * $signed({1'b0, ctl_s1.fb});
	assign pwet_c   = $signed(delayed) * $signed({1'b0, ctl_s1.mix});
	assign pdry_c   = $signed(in_s1) * $signed(dry_gain);

	// stage 2: round half up, sum and saturate
	assign fb_round  = {pfb_s2[PW-1], pfb_s2} + (W + 18)'(sfd_pkg::ROUND_HALF);
	assign back_sum  = {fb_round[W+17], fb_round[W+17:15]} + {{4{in_s2[W-1]}}, in_s2};
	assign out_round = {{2{pdry_s2[PW-1]}}, pdry_s2} + {{2{pwet_s2[PW-1]}}, pwet_s2}
		+ (W + 19)'(sfd_pkg::ROUND_HALF);
	assign back_sat  = sat(back_sum);
	assign out_sat   = sat(out_round[W+18:15]);
	assign wen_s2    = v_s2 && !bypass_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1 <= ctl;
			in_s1  <= smp;
			wa_s1  <= wr_addr;
		end
		bypass_s2 <= ctl_s1.bypass;
		in_s2     <= in_s1;
		wa_s2     <= wa_s1;
		pfb_s2    <= pfb_c;
		pwet_s2   <= pwet_c;
		pdry_s2   <= pdry_c;
		out_s3    <= bypass_s2 ? in_s2 : out_sat;
	end

	assign out_valid = v_s3;
	assign out_smp   = out_s3;

endmodule

[rtl/stereo_feedback_delay.sv]
// stereo feedback delay top level: register port, store pointers, two channel lanes
// and the output queue that merges them; depends on sfd_pkg, sfd_rem, sfd_lane
`timescale 1ns / 1ps

// One stereo frame is taken per transaction and one mixed frame is returned for it. Frames
// are taken one per cycle as long as the delay is three frames or more and no register
// write, delay reduction or full set of frames in flight holds the input off; at a delay of
// one or two frames the read of the echo waits for the write-back of the frame before it.
// Each lane owns one store with one read and one write port, and the store is never swept:
// entries not yet written since reset read as zero from the fill position of the write
// pointer. A write to the delay register starts a reduction of the delay by the store
// depth, and no frame is taken until it ends. Finished frames wait in an eight-entry queue;
// at most eight frames are in flight, so the input is held off once eight frames are taken
// and not yet returned.
module stereo_feedback_delay #(
	parameter int STORE_DEPTH = sfd_pkg::SFD_STORE_DEPTH,
	parameter int SAMPLE_BITS = sfd_pkg::SFD_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sfd_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [sfd_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [sfd_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_BITS-1:0]              left_in,
	input  logic [SAMPLE_BITS-1:0]              right_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [SAMPLE_BITS-1:0]              left_out,
	output logic [SAMPLE_BITS-1:0]              right_out
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int QD = sfd_pkg::OUT_DEPTH;
	localparam int QA = $clog2(QD);
	localparam int QC = $clog2(QD + 1);
	localparam int DB = sfd_pkg::DELAY_BITS;
	localparam int GB = sfd_pkg::GAIN_BITS;

	logic [DB-1:0] delay_q;
	logic [GB-1:0] fb_q;
	logic [GB-1:0] mix_q;
	logic          cfg_wr;

	logic [AW-1:0] dmod;
	logic          rem_busy;

	logic [AW-1:0] wp_q;
	logic          wrapped_q;
	logic [AW:0]   diff;
	logic [AW:0]   diff_wrap;
	logic [AW-1:0] rd_c;
	logic          bypass_c;
	logic          hazard;
	sfd_pkg::sfd_ctl_t ctl_c;
	logic          in_acc;

	logic          pw_v_s1;
	logic [AW-1:0] pw_a_s1;
	logic          pw_v_s2;
	logic [AW-1:0] pw_a_s2;

	logic                   l_valid;
	logic                   r_valid;
	logic [SAMPLE_BITS-1:0] l_smp;
	logic [SAMPLE_BITS-1:0] r_smp;

	logic [2*SAMPLE_BITS-1:0] queue_q [QD];
	logic [QA-1:0] qw_q;
	logic [QA-1:0] qr_q;
	logic [QC-1:0] ocnt_q;
	logic [QC-1:0] cnt_q;
	logic          pop;
	logic          push;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			fb_q    <= '0;
			mix_q   <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				sfd_pkg::REG_DELAY:    delay_q <= pwdata[DB-1:0];
				sfd_pkg::REG_FEEDBACK: fb_q    <= pwdata[GB-1:0];
				sfd_pkg::REG_MIX:      mix_q   <= pwdata[GB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			sfd_pkg::REG_DELAY:    prdata = 32'(delay_q);
			sfd_pkg::REG_FEEDBACK: prdata = 32'(fb_q);
			sfd_pkg::REG_MIX:      prdata = 32'(mix_q);
			default:               prdata = '0;
		endcase
	end

	sfd_rem #(
		.DEPTH(STORE_DEPTH)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cfg_wr && paddr[3:2] == sfd_pkg::REG_DELAY),
		.dividend(pwdata[DB-1:0]),
		.rem     (dmod),
		.busy    (rem_busy)
	);

	// read address and fill check
	assign diff      = {1'b0, wp_q} - {1'b0, dmod};
	assign diff_wrap = diff + (AW + 1)'(STORE_DEPTH);
	assign rd_c      = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
	assign bypass_c  = (delay_q == '0);
	assign hazard    = !bypass_c &&
		((pw_v_s1 && pw_a_s1 == rd_c) || (pw_v_s2 && pw_a_s2 == rd_c));

	assign ctl_c.bypass = bypass_c;
	assign ctl_c.hit    = wrapped_q || (rd_c < wp_q);
	assign ctl_c.fb     = (fb_q > sfd_pkg::GAIN_ONE) ? sfd_pkg::GAIN_ONE : fb_q;
	assign ctl_c.mix    = (mix_q > sfd_pkg::GAIN_ONE) ? sfd_pkg::GAIN_ONE : mix_q;

	assign in_ready = (cnt_q < QC'(QD)) && !rem_busy && !hazard && !cfg_wr;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			pw_v_s1   <= 1'b0;
			pw_v_s2   <= 1'b0;
		end else begin
			pw_v_s1 <= in_acc && !bypass_c;
			pw_v_s2 <= pw_v_s1;
			if (in_acc && !bypass_c) begin
				if (wp_q == AW'(STORE_DEPTH - 1)) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pw_a_s1 <= wp_q;
		pw_a_s2 <= pw_a_s1;
	end

	sfd_lane #(
		.DEPTH(STORE_DEPTH),
		.W    (SAMPLE_BITS)
	) u_lane_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (in_acc),
		.smp      (left_in),
		.rd_addr  (rd_c),
		.wr_addr  (wp_q),
		.ctl      (ctl_c),
		.out_valid(l_valid),
		.out_smp  (l_smp)
	);

	sfd_lane #(
		.DEPTH(STORE_DEPTH),
		.W    (SAMPLE_BITS)
	) u_lane_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (in_acc),
		.smp      (right_in),
		.rd_addr  (rd_c),
		.wr_addr  (wp_q),
		.ctl      (ctl_c),
		.out_valid(r_valid),
		.out_smp  (r_smp)
	);

	// merge the lanes into the output queue
	assign push      = l_valid;
	assign out_valid = (ocnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign left_out  = queue_q[qr_q][2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign right_out = queue_q[qr_q][SAMPLE_BITS-1:0];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[qw_q] <= {l_smp, r_smp};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q   <= '0;
			qr_q   <= '0;
			ocnt_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				qw_q <= qw_q + QA'(1);
			end
			if (pop) begin
				qr_q <= qr_q + QA'(1);
			end
			case ({push, pop})
				2'b10:   ocnt_q <= ocnt_q + QC'(1);
				2'b01:   ocnt_q <= ocnt_q - QC'(1);
				default: ocnt_q <= ocnt_q;
			endcase
			case ({in_acc, pop})
				2'b10:   cnt_q <= cnt_q + QC'(1);
				2'b01:   cnt_q <= cnt_q - QC'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (ocnt_q != QC'(QD) || pop))
		else $error("output queue overflow");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		l_valid == r_valid)
		else $error("lanes out of step");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !rem_busy)
		else $error("transaction taken during delay reduction");

	a_credit_covers: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= cnt_q)
		else $error("queue holds more than in flight");

endmodule
